// ===== rtl/sorted_sparse_table_engine_top_macros.svh =====
// Assertion macros shared by the sorted sparse table engine modules.
`ifndef SORTED_SPARSE_TABLE_ENGINE_TOP_MACROS_SVH
`define SORTED_SPARSE_TABLE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SSTE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sste assertion failed");
// Next-cycle implication.
`define SSTE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sste assertion failed");
`else
`define SSTE_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSTE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sste_pkg.sv =====
// Shared types and constants of the sorted sparse table engine.
package sste_pkg;

   localparam int DEPTH_DEF     = 1024;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int DATA_WIDTH    = 32;
   localparam int LEN_WIDTH     = 11;
   localparam int FUNC_WIDTH    = 4;
   localparam int STATUS_WIDTH  = 3;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FN_GET           = 4'd0,
      FN_SET           = 4'd1,
      FN_SWAP          = 4'd2,
      FN_APPEND        = 4'd3,
      FN_FIND          = 4'd4,
      FN_INSERT        = 4'd5,
      FN_INSERT_UNIQUE = 4'd6,
      FN_REMOVE        = 4'd7,
      FN_FIRST         = 4'd8,
      FN_LAST          = 4'd9,
      FN_CLEAR         = 4'd10
   } func_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_EXISTS    = 3'd1,
      ST_INVALID   = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      RA_OFF, RA_ZERO, RA_LAST, RA_MID, RA_STEP, RA_SH1, RA_SH2
   } raddr_sel_type;

   typedef enum logic [1:0] {WA_OFF, WA_COUNT, WA_SHIFT, WA_SLOT} waddr_sel_type;
   typedef enum logic [1:0] {WD_KEY, WD_ZERO, WD_RDATA} wdata_sel_type;
   typedef enum logic [2:0] {CN_HOLD, CN_INC, CN_DEC, CN_CLEAR, CN_OFF1} cnt_op_type;
   typedef enum logic {VL_HOLD, VL_RDATA} val_op_type;
   typedef enum logic [2:0] {PS_HOLD, PS_IDX, PS_COUNT, PS_HIT, PS_SLOT} pos_op_type;
   typedef enum logic [2:0] {
      SR_NONE, SR_INIT, SR_PROBE, SR_STEP, SR_LEFT, SR_RIGHT
   } srch_op_type;
   typedef enum logic [1:0] {SH_NONE, SH_UP, SH_DOWN, SH_ADV} sh_op_type;

   typedef struct packed {
      logic          load;
      logic          rd_en;
      raddr_sel_type raddr_sel;
      logic          wr_en;
      waddr_sel_type waddr_sel;
      wdata_sel_type wdata_sel;
      cnt_op_type    cnt_op;
      logic          st_we;
      status_type    st_code;
      val_op_type    val_op;
      pos_op_type    pos_op;
      srch_op_type   srch_op;
      sh_op_type     sh_op;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic below;
      logic inrange;
      logic off_ok;
      logic full;
      logic empty;
      logic rd_zero;
      logic key_zero;
      logic off_last;
      logic lr_lt;
      logic i_gt_left;
      logic key_eq;
      logic key_lt;
      logic key_le;
      logic sh_done;
      logic sh_next_done;
      logic fill_done;
   } flags_type;

endpackage

// ===== rtl/sste_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sste_ram
   import sste_pkg::*;
#(
   parameter int WIDTH = KEY_WIDTH_DEF,
   parameter int DEPTH = DEPTH_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sste_datapath.sv =====
// Datapath: table memory, fill count, search and shift pointers, result registers.
`include "sorted_sparse_table_engine_top_macros.svh"
module sste_datapath
   import sste_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output flags_type               flags,
   input  logic [FUNC_WIDTH-1:0]   req_func,
   input  logic [DATA_WIDTH-1:0]   req_index,
   input  logic [DATA_WIDTH-1:0]   req_item,
   input  logic                    csr_valid,
   input  logic [DATA_WIDTH-1:0]   csr_data,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [DATA_WIDTH-1:0]   rsp_value,
   output logic [DATA_WIDTH-1:0]   rsp_position,
   output logic [LEN_WIDTH-1:0]    rsp_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [DATA_WIDTH-1:0] DEPTH_W = DATA_WIDTH'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_WIDTH);

   logic [DATA_WIDTH-1:0] base_ff, idx_ff, off_ff, value_ff, pos_ff;
   logic [FUNC_WIDTH-1:0] func_ff;
   logic [KEY_WIDTH-1:0]  key_ff;
   logic                  below_ff;
   logic [CW-1:0]         count_ff, left_ff, right_ff;
   logic [AW-1:0]         mid_ff, i_ff, p_ff, end_ff;
   logic                  up_ff;
   status_type            status_ff;

   logic [STATUS_WIDTH-1:0] rsp_status_ff;
   logic [DATA_WIDTH-1:0]   rsp_value_ff, rsp_position_ff;
   logic [LEN_WIDTH-1:0]    rsp_length_ff;

   logic [63:0]          key_wide, rd_wide;
   logic [CW:0]          lr_sum;
   logic [AW-1:0]        mid_next, p_step1, p_step2;
   logic [KEY_WIDTH-1:0] rdata, wdata;
   logic [AW-1:0]        raddr, waddr;

   assign key_wide = 64'(req_item) & KEY_MASK;
   assign rd_wide  = 64'(rdata);
   assign lr_sum   = {1'b0, left_ff} + {1'b0, right_ff};
   assign mid_next = lr_sum[AW:1];
   assign p_step1  = up_ff ? p_ff - AW'(1) : p_ff + AW'(1);
   assign p_step2  = up_ff ? p_ff - AW'(2) : p_ff + AW'(2);

   always_comb begin
      unique case (cmd.raddr_sel)
         RA_OFF:  raddr = off_ff[AW-1:0];
         RA_ZERO: raddr = '0;
         RA_LAST: raddr = AW'(count_ff - CW'(1));
         RA_MID:  raddr = mid_next;
         RA_STEP: raddr = i_ff - AW'(1);
         RA_SH1:  raddr = p_step1;
         RA_SH2:  raddr = p_step2;
         default: raddr = '0;
      endcase
      unique case (cmd.waddr_sel)
         WA_OFF:   waddr = off_ff[AW-1:0];
         WA_COUNT: waddr = count_ff[AW-1:0];
         WA_SHIFT: waddr = p_ff;
         WA_SLOT:  waddr = left_ff[AW-1:0];
         default:  waddr = '0;
      endcase
      unique case (cmd.wdata_sel)
         WD_KEY:   wdata = key_ff;
         WD_ZERO:  wdata = '0;
         WD_RDATA: wdata = rdata;
         default:  wdata = '0;
      endcase
   end

   sste_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   always_comb begin
      flags.func         = func_ff;
      flags.below        = below_ff;
      flags.inrange      = !below_ff && (off_ff < DATA_WIDTH'(count_ff));
      flags.off_ok       = off_ff < DEPTH_W;
      flags.full         = count_ff == DEPTH_C;
      flags.empty        = count_ff == '0;
      flags.rd_zero      = rdata == '0;
      flags.key_zero     = key_ff == '0;
      flags.off_last     = (off_ff + DATA_WIDTH'(1)) == DATA_WIDTH'(count_ff);
      flags.lr_lt        = left_ff < right_ff;
      flags.i_gt_left    = CW'(i_ff) > left_ff;
      flags.key_eq       = key_ff == rdata;
      flags.key_lt       = key_ff < rdata;
      flags.key_le       = key_ff <= rdata;
      flags.sh_done      = p_ff == end_ff;
      flags.sh_next_done = p_step1 == end_ff;
      flags.fill_done    = DATA_WIDTH'(count_ff) == off_ff;
   end

   // configuration register and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid) begin
            base_ff <= csr_data;
         end
         unique case (cmd.cnt_op)
            CN_HOLD:  count_ff <= count_ff;
            CN_INC:   count_ff <= count_ff + CW'(1);
            CN_DEC:   count_ff <= count_ff - CW'(1);
            CN_CLEAR: count_ff <= '0;
            CN_OFF1:  count_ff <= CW'(off_ff) + CW'(1);
            default:  count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         idx_ff    <= req_index;
         key_ff    <= key_wide[KEY_WIDTH-1:0];
         off_ff    <= req_index - base_ff;
         below_ff  <= req_index < base_ff;
         status_ff <= ST_OK;
         value_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         if (cmd.st_we) begin
            status_ff <= cmd.st_code;
         end
         if (cmd.val_op == VL_RDATA) begin
            value_ff <= rd_wide[DATA_WIDTH-1:0];
         end
         unique case (cmd.pos_op)
            PS_HOLD:  pos_ff <= pos_ff;
            PS_IDX:   pos_ff <= idx_ff;
            PS_COUNT: pos_ff <= DATA_WIDTH'(count_ff) + base_ff;
            PS_HIT:   pos_ff <= DATA_WIDTH'(i_ff) + base_ff;
            PS_SLOT:  pos_ff <= DATA_WIDTH'(left_ff) + base_ff;
            default:  pos_ff <= pos_ff;
         endcase
      end

      unique case (cmd.srch_op)
         SR_NONE: ;
         SR_INIT: begin
            left_ff  <= '0;
            right_ff <= count_ff;
         end
         SR_PROBE: begin
            mid_ff <= mid_next;
            i_ff   <= mid_next;
         end
         SR_STEP:  i_ff     <= i_ff - AW'(1);
         SR_LEFT:  left_ff  <= CW'(mid_ff) + CW'(1);
         SR_RIGHT: right_ff <= CW'(mid_ff);
         default: ;
      endcase

      unique case (cmd.sh_op)
         SH_NONE: ;
         SH_UP: begin
            up_ff  <= 1'b1;
            p_ff   <= count_ff[AW-1:0];
            end_ff <= left_ff[AW-1:0];
         end
         SH_DOWN: begin
            up_ff  <= 1'b0;
            p_ff   <= off_ff[AW-1:0];
            end_ff <= AW'(count_ff - CW'(1));
         end
         SH_ADV:  p_ff <= p_step1;
         default: ;
      endcase

      if (cmd.rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_value_ff    <= value_ff;
         rsp_position_ff <= pos_ff;
         rsp_length_ff   <= LEN_WIDTH'(count_ff);
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_length   = rsp_length_ff;

   `SSTE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `SSTE_ASSERT_NXT(a_probe_window, clock, reset, cmd.srch_op == SR_PROBE, left_ff <= right_ff)

endmodule

// ===== rtl/sste_ctrl.sv =====
// Controller: sequences each operation and drives the datapath commands.
`include "sorted_sparse_table_engine_top_macros.svh"
module sste_ctrl
   import sste_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   input  flags_type flags,
   output cmd_type   cmd
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_DISP    = 12'b000000000010,
      S_RDWAIT  = 12'b000000000100,
      S_SETW    = 12'b000000001000,
      S_FILL    = 12'b000000010000,
      S_SRCH    = 12'b000000100000,
      S_SCMP    = 12'b000001000000,
      S_REMW    = 12'b000010000000,
      S_SHPRIME = 12'b000100000000,
      S_SHIFT   = 12'b001000000000,
      S_KEYWR   = 12'b010000000000,
      S_DONE    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      is_ins;

   assign is_ins    = flags.func == FN_INSERT;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            unique case (flags.func)
               FN_GET: begin
                  if (flags.inrange) begin
                     cmd.rd_en = 1'b1;
                     cmd.raddr_sel = RA_OFF;
                     state_in = S_RDWAIT;
                  end else begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_INVALID;
                  end
               end
               FN_SET, FN_SWAP: begin
                  priority if (flags.below) begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_INVALID;
                  end else if (flags.inrange) begin
                     cmd.rd_en = 1'b1;
                     cmd.raddr_sel = RA_OFF;
                     state_in = S_SETW;
                  end else if (!flags.off_ok) begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_FULL;
                  end else begin
                     state_in = S_FILL;
                  end
               end
               FN_APPEND: begin
                  if (flags.full) begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_FULL;
                  end else begin
                     cmd.wr_en = 1'b1;
                     cmd.waddr_sel = WA_COUNT;
                     cmd.wdata_sel = WD_KEY;
                     cmd.pos_op = PS_COUNT;
                     cmd.cnt_op = CN_INC;
                  end
               end
               FN_FIND, FN_INSERT, FN_INSERT_UNIQUE: begin
                  if (flags.full && flags.func != FN_FIND) begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_FULL;
                  end else begin
                     cmd.srch_op = SR_INIT;
                     state_in = S_SRCH;
                  end
               end
               FN_REMOVE: begin
                  if (flags.inrange) begin
                     cmd.rd_en = 1'b1;
                     cmd.raddr_sel = RA_OFF;
                     state_in = S_REMW;
                  end else begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_INVALID;
                  end
               end
               FN_FIRST, FN_LAST: begin
                  if (flags.empty) begin
                     cmd.st_we = 1'b1;
                     cmd.st_code = ST_NOT_FOUND;
                  end else begin
                     cmd.rd_en = 1'b1;
                     cmd.raddr_sel = (flags.func == FN_FIRST) ? RA_ZERO : RA_LAST;
                     state_in = S_RDWAIT;
                  end
               end
               FN_CLEAR: cmd.cnt_op = CN_CLEAR;
               default: ;
            endcase
         end
         S_RDWAIT: begin
            cmd.val_op = VL_RDATA;
            state_in = S_DONE;
         end
         S_SETW: begin
            state_in = S_DONE;
            priority if (flags.rd_zero) begin
               cmd.wr_en = 1'b1;
               cmd.waddr_sel = WA_OFF;
               cmd.wdata_sel = WD_KEY;
            end else if (flags.func == FN_SET) begin
               cmd.st_we = 1'b1;
               cmd.st_code = ST_EXISTS;
               cmd.val_op = VL_RDATA;
               cmd.pos_op = PS_IDX;
            end else begin
               cmd.val_op = VL_RDATA;
               if (flags.key_zero && flags.off_last) begin
                  cmd.cnt_op = CN_DEC;
               end else begin
                  cmd.wr_en = 1'b1;
                  cmd.waddr_sel = WA_OFF;
                  cmd.wdata_sel = WD_KEY;
               end
            end
         end
         S_FILL: begin
            // pad the gap with empty slots, then place the key
            cmd.wr_en = 1'b1;
            if (flags.fill_done) begin
               cmd.waddr_sel = WA_OFF;
               cmd.wdata_sel = WD_KEY;
               cmd.cnt_op = CN_OFF1;
               state_in = S_DONE;
            end else begin
               cmd.waddr_sel = WA_COUNT;
               cmd.wdata_sel = WD_ZERO;
               cmd.cnt_op = CN_INC;
            end
         end
         S_SRCH: begin
            priority if (flags.lr_lt) begin
               cmd.srch_op = SR_PROBE;
               cmd.rd_en = 1'b1;
               cmd.raddr_sel = RA_MID;
               state_in = S_SCMP;
            end else if (flags.func == FN_FIND) begin
               cmd.st_we = 1'b1;
               cmd.st_code = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               cmd.sh_op = SH_UP;
               state_in = S_SHPRIME;
            end
         end
         S_SCMP: begin
            state_in = S_SRCH;
            priority if (flags.rd_zero && flags.i_gt_left) begin
               cmd.srch_op = SR_STEP;
               cmd.rd_en = 1'b1;
               cmd.raddr_sel = RA_STEP;
               state_in = S_SCMP;
            end else if (flags.rd_zero) begin
               cmd.srch_op = SR_LEFT;
            end else if (!is_ins && flags.key_eq) begin
               cmd.val_op = VL_RDATA;
               cmd.pos_op = PS_HIT;
               cmd.st_we = flags.func == FN_INSERT_UNIQUE;
               cmd.st_code = ST_EXISTS;
               state_in = S_DONE;
            end else if (is_ins ? flags.key_le : flags.key_lt) begin
               cmd.srch_op = SR_RIGHT;
            end else begin
               cmd.srch_op = SR_LEFT;
            end
         end
         S_REMW: begin
            cmd.val_op = VL_RDATA;
            cmd.cnt_op = CN_DEC;
            cmd.sh_op = SH_DOWN;
            state_in = S_SHPRIME;
         end
         S_SHPRIME: begin
            if (flags.sh_done) begin
               state_in = (flags.func == FN_REMOVE) ? S_DONE : S_KEYWR;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.raddr_sel = RA_SH1;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // move one entry per cycle while fetching the next
            cmd.wr_en = 1'b1;
            cmd.waddr_sel = WA_SHIFT;
            cmd.wdata_sel = WD_RDATA;
            cmd.sh_op = SH_ADV;
            if (flags.sh_next_done) begin
               state_in = (flags.func == FN_REMOVE) ? S_DONE : S_KEYWR;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.raddr_sel = RA_SH2;
            end
         end
         S_KEYWR: begin
            cmd.wr_en = 1'b1;
            cmd.waddr_sel = WA_SLOT;
            cmd.wdata_sel = WD_KEY;
            cmd.cnt_op = CN_INC;
            cmd.pos_op = PS_SLOT;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SSTE_ASSERT_NXT(a_accept_dispatch, clock, reset, req_valid && req_ready, state_ff == S_DISP)
   `SSTE_ASSERT_NXT(a_load_shows, clock, reset, cmd.rsp_load, rsp_valid_ff)

endmodule

// ===== rtl/sorted_sparse_table_engine_top.sv =====
// Top level of the sorted sparse table engine: controller, datapath and ports.
// Get, first, last and set within the count read the table before answering; append, clear
// and error answers need no read; set past the count pads each gap slot with an empty entry;
// find probes by binary search, stepping over empty slots; insert and remove shift entries.
// One item at a time: the worst case is set by the empty-slot steps of the search plus the
// shift loop over the table memory, which has separate read and write ports. Reset clears the
// fill count, index base and handshake state; table contents are not cleared and need no pass.
module sorted_sparse_table_engine_top
   import sste_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [FUNC_WIDTH-1:0]   req_func,
   input  logic [DATA_WIDTH-1:0]   req_index,
   input  logic [DATA_WIDTH-1:0]   req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [DATA_WIDTH-1:0]   rsp_value,
   output logic [DATA_WIDTH-1:0]   rsp_position,
   output logic [LEN_WIDTH-1:0]    rsp_length,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [DATA_WIDTH-1:0]   csr_data
);

   cmd_type   cmd;
   flags_type flags;

   // index base is a plain register; take every write at once
   assign csr_ready = 1'b1;

   // sequence each item through read, search, pad and shift steps
   sste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // hold the table, fill count, pointers and the result register
   sste_datapath #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .flags        (flags),
      .req_func     (req_func),
      .req_index    (req_index),
      .req_item     (req_item),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_length   (rsp_length)
   );

endmodule
